// ===== rtl/ps2rb_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ps2rb_pkg
// Shared types and constants for the PS/2 port receive/transmit ring buffers.
// ----------------------------------------------------------------------------
package ps2rb_pkg;

  localparam int DATA_W    = 8;
  localparam int COUNT_W   = 8;
  localparam int FUNC_W    = 2;
  localparam int IN_TDATA_W  = 24;
  localparam int OUT_TDATA_W = 32;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_WR = 2'd0,
    FUNC_RD = 2'd1,
    FUNC_EV = 2'd2
  } func_t;

  typedef struct packed {
    logic               read_valid;
    logic               tx_accepted;
    logic               send_valid;
    logic               send_fwd;
    logic               rx_dropped;
    logic [COUNT_W-1:0] rx_count;
  } flags_t;

endpackage
`default_nettype wire

// ===== rtl/ps2rb_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ps2rb_ram
// Byte-wide ring storage: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module ps2rb_ram #(
  parameter int DEPTH = 16
) (
  input  wire logic                                clk,
  input  wire logic                                we,
  input  wire logic [$clog2(DEPTH)-1:0]            waddr,
  input  wire logic [ps2rb_pkg::DATA_W-1:0]        wdata,
  input  wire logic                                re,
  input  wire logic [$clog2(DEPTH)-1:0]            raddr,
  output logic      [ps2rb_pkg::DATA_W-1:0]        rdata
);
  import ps2rb_pkg::*;

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

// ===== rtl/ps2rb_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ps2rb_ctrl
// Ring pointers: decide each transaction's ring accesses and result flags.
// ----------------------------------------------------------------------------
module ps2rb_ctrl #(
  parameter int DEPTH = 16
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         accept,
  input  wire ps2rb_pkg::func_t             func,
  input  wire logic                         port_recv,
  input  wire logic                         port_cts,
  output logic                              rx_we,
  output logic      [$clog2(DEPTH)-1:0]     rx_waddr,
  output logic                              rx_re,
  output logic      [$clog2(DEPTH)-1:0]     rx_raddr,
  output logic                              tx_we,
  output logic      [$clog2(DEPTH)-1:0]     tx_waddr,
  output logic                              tx_re,
  output logic      [$clog2(DEPTH)-1:0]     tx_raddr,
  output ps2rb_pkg::flags_t                 flags
);
  import ps2rb_pkg::*;

  localparam int PTR_W = $clog2(DEPTH);

  logic [PTR_W-1:0] rx_head_r, rx_head_nxt;
  logic [PTR_W-1:0] rx_tail_r, rx_tail_nxt;
  logic [PTR_W-1:0] tx_head_r, tx_head_nxt;
  logic [PTR_W-1:0] tx_tail_r, tx_tail_nxt;
  logic [PTR_W-1:0] rx_head_inc, rx_tail_inc, tx_head_inc, tx_tail_inc;
  logic [PTR_W-1:0] rx_fill;
  logic             do_wr, do_rd, do_step;
  logic             tx_push, rx_push, rx_pop, tx_pop;

  assign rx_head_inc = rx_head_r + PTR_W'(1);
  assign rx_tail_inc = rx_tail_r + PTR_W'(1);
  assign tx_head_inc = tx_head_r + PTR_W'(1);
  assign tx_tail_inc = tx_tail_r + PTR_W'(1);

  always_comb begin
    do_wr   = 1'b0;
    do_rd   = 1'b0;
    do_step = 1'b0;
    case (func)
      FUNC_WR: begin
        do_wr   = 1'b1;
        do_step = 1'b1;
      end
      FUNC_RD: begin
        do_rd = 1'b1;
      end
      FUNC_EV: begin
        do_step = 1'b1;
      end
      default: begin
        do_wr = 1'b0;
      end
    endcase
  end

  always_comb begin
    tx_push     = do_wr && (tx_head_inc != tx_tail_r);
    tx_head_nxt = tx_push ? tx_head_inc : tx_head_r;
    rx_push     = do_step && port_recv && (rx_head_inc != rx_tail_r);
    rx_head_nxt = rx_push ? rx_head_inc : rx_head_r;
    rx_pop      = do_rd && (rx_head_r != rx_tail_r);
    rx_tail_nxt = rx_pop ? rx_tail_inc : rx_tail_r;
    tx_pop      = do_step && port_cts && (tx_tail_r != tx_head_nxt);
    tx_tail_nxt = tx_pop ? tx_tail_inc : tx_tail_r;
    rx_fill     = rx_head_nxt - rx_tail_nxt;
  end

  always_comb begin
    rx_we    = accept && rx_push;
    rx_waddr = rx_head_r;
    rx_re    = accept && rx_pop;
    rx_raddr = rx_tail_r;
    tx_we    = accept && tx_push;
    tx_waddr = tx_head_r;
    tx_re    = accept && tx_pop;
    tx_raddr = tx_tail_r;

    flags.read_valid  = rx_pop;
    flags.tx_accepted = tx_push;
    flags.send_valid  = tx_pop;
    // same entry written and read in one transaction: take the incoming byte
    flags.send_fwd    = tx_pop && tx_push && (tx_tail_r == tx_head_r);
    flags.rx_dropped  = do_step && port_recv && !rx_push;
    flags.rx_count    = COUNT_W'(rx_fill);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rx_head_r <= '0;
      rx_tail_r <= '0;
      tx_head_r <= '0;
      tx_tail_r <= '0;
    end else if (accept) begin
      rx_head_r <= rx_head_nxt;
      rx_tail_r <= rx_tail_nxt;
      tx_head_r <= tx_head_nxt;
      tx_tail_r <= tx_tail_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/ps2_port_rx_tx_ring_buffers_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ps2_port_rx_tx_ring_buffers_core
// Receive and transmit byte rings between a CPU and one PS/2 port.
//
//   channel | ports                     | contents
//   --------+---------------------------+------------------------------------
//   in      | in_tvalid/tready/tdata/tuser | one operation per transaction
//   out     | out_tvalid/tready/tdata   | one result per operation
//
// One transaction per cycle while in_tready is high; a result passes through the
// registered read of the ring memories and then the output register. Pointers
// update at acceptance, so the next transaction sees them.
// Reset clears the four ring pointers; ring contents are not cleared.
// Output stalls back up through one holding stage to in_tready.
// ----------------------------------------------------------------------------
module ps2_port_rx_tx_ring_buffers_core #(
  parameter int RING_DEPTH = 16
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic                                 in_tvalid,
  output logic                                      in_tready,
  // tx_data[7:0], port_recv[8], port_data[16:9], port_cts[17], zero[23:18]
  input  wire logic [ps2rb_pkg::IN_TDATA_W-1:0]     in_tdata,
  // func[1:0]
  input  wire logic [ps2rb_pkg::FUNC_W-1:0]         in_tuser,
  output logic                                      out_tvalid,
  input  wire logic                                 out_tready,
  // read_data[7:0], read_valid[8], rx_count[16:9], tx_accepted[17],
  // send_valid[18], send_data[26:19], rx_dropped[27], zero[31:28]
  output logic      [ps2rb_pkg::OUT_TDATA_W-1:0]    out_tdata
);
  import ps2rb_pkg::*;

  localparam int PTR_W = $clog2(RING_DEPTH);

  logic              accept;
  logic              rx_we, rx_re, tx_we, tx_re;
  logic [PTR_W-1:0]  rx_waddr, rx_raddr, tx_waddr, tx_raddr;
  logic [DATA_W-1:0] rx_q, tx_q;
  flags_t            flags;

  logic              s1_v_r, s1_v_nxt;
  flags_t            s1_flags_r;
  logic [DATA_W-1:0] s1_fwd_r;
  logic              out_v_r, out_v_nxt;
  logic [OUT_TDATA_W-1:0] out_data_r, out_data_nxt;
  logic              out_load;
  logic [DATA_W-1:0] rd_byte, snd_byte;

  assign accept = in_tvalid && in_tready;

  ps2rb_ctrl #(.DEPTH(RING_DEPTH)) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .func      (func_t'(in_tuser)),
    .port_recv (in_tdata[8]),
    .port_cts  (in_tdata[17]),
    .rx_we     (rx_we),
    .rx_waddr  (rx_waddr),
    .rx_re     (rx_re),
    .rx_raddr  (rx_raddr),
    .tx_we     (tx_we),
    .tx_waddr  (tx_waddr),
    .tx_re     (tx_re),
    .tx_raddr  (tx_raddr),
    .flags     (flags)
  );

  ps2rb_ram #(.DEPTH(RING_DEPTH)) u_rx_ram (
    .clk   (clk),
    .we    (rx_we),
    .waddr (rx_waddr),
    .wdata (in_tdata[16:9]),
    .re    (rx_re),
    .raddr (rx_raddr),
    .rdata (rx_q)
  );

  ps2rb_ram #(.DEPTH(RING_DEPTH)) u_tx_ram (
    .clk   (clk),
    .we    (tx_we),
    .waddr (tx_waddr),
    .wdata (in_tdata[7:0]),
    .re    (tx_re),
    .raddr (tx_raddr),
    .rdata (tx_q)
  );

  always_comb begin
    out_load  = s1_v_r && (!out_v_r || out_tready);
    in_tready = !s1_v_r || out_load;
    s1_v_nxt  = accept ? 1'b1 : (out_load ? 1'b0 : s1_v_r);
    out_v_nxt = out_load ? 1'b1 : (out_tready ? 1'b0 : out_v_r);

    rd_byte  = s1_flags_r.read_valid ? rx_q : '0;
    snd_byte = !s1_flags_r.send_valid ? '0 : (s1_flags_r.send_fwd ? s1_fwd_r : tx_q);
    out_data_nxt = {4'd0, s1_flags_r.rx_dropped, snd_byte, s1_flags_r.send_valid,
                    s1_flags_r.tx_accepted, s1_flags_r.rx_count,
                    s1_flags_r.read_valid, rd_byte};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      s1_v_r  <= s1_v_nxt;
      out_v_r <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_flags_r <= flags;
      s1_fwd_r   <= in_tdata[7:0];
    end
    if (out_load) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = out_data_r;

  a_read_no_port: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !(out_tdata[8] && (out_tdata[18] || out_tdata[17] || out_tdata[27])))
    else $error("cpu read result shows port activity");

  a_send_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tdata[18]) |-> (out_tdata[26:19] == '0))
    else $error("send_data nonzero without send_valid");

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (32'(out_tdata[16:9]) < 32'(RING_DEPTH)))
    else $error("rx_count exceeds ring capacity");

  a_fwd_send: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_v_r && s1_flags_r.send_fwd) |-> (s1_flags_r.send_valid && s1_flags_r.tx_accepted))
    else $error("forwarded send without write and send");

endmodule
`default_nettype wire

// ===== dv/ps2_port_rx_tx_ring_buffers_core_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ps2_port_rx_tx_ring_buffers_core_test
// Streams CPU writes, CPU reads, port events and the unused op code into the
// ring buffer core. It checks every result against a scoreboard that keeps
// its own receive and transmit rings. Both sides idle and stall in phases,
// with one long output hold-off and two full drains.
// ----------------------------------------------------------------------------
module ps2_port_rx_tx_ring_buffers_core_test;
  import ps2rb_pkg::*;

  localparam int          RING_DEPTH  = 16;
  localparam int          PTR_W       = $clog2(RING_DEPTH);
  localparam logic [1:0]  FUNC_NOP    = 2'd3;
  localparam int          CYCLE_LIMIT = 400000;

  typedef struct packed {
    logic [5:0] pad;
    logic       port_cts;
    logic [7:0] port_data;
    logic       port_recv;
    logic [7:0] tx_data;
  } op_word_t;

  typedef struct packed {
    logic [3:0] pad;
    logic       rx_dropped;
    logic [7:0] send_data;
    logic       send_valid;
    logic       tx_accepted;
    logic [7:0] rx_count;
    logic       read_valid;
    logic [7:0] read_data;
  } result_word_t;

  class ps2_ring_scoreboard;
    logic [7:0]       rx_ring[RING_DEPTH];
    logic [7:0]       tx_ring[RING_DEPTH];
    logic [PTR_W-1:0] rx_wr;
    logic [PTR_W-1:0] rx_rd;
    logic [PTR_W-1:0] tx_wr;
    logic [PTR_W-1:0] tx_rd;
    result_word_t     due_results[$];
    int               errors;

    function new();
      rx_wr  = '0;
      rx_rd  = '0;
      tx_wr  = '0;
      tx_rd  = '0;
      errors = 0;
    endfunction

    function int pending();
      return due_results.size();
    endfunction

    function void run_port_step(op_word_t op, ref result_word_t r);
      if (op.port_recv) begin
        if (PTR_W'(rx_wr + 1'b1) == rx_rd) begin
          r.rx_dropped = 1'b1;
        end else begin
          rx_ring[rx_wr] = op.port_data;
          rx_wr          = rx_wr + 1'b1;
        end
      end
      if (op.port_cts && tx_rd != tx_wr) begin
        r.send_valid = 1'b1;
        r.send_data  = tx_ring[tx_rd];
        tx_rd        = tx_rd + 1'b1;
      end
    endfunction

    function void note_op(logic [1:0] func, op_word_t op);
      result_word_t r;
      r = '0;
      case (func)
        FUNC_WR: begin
          if (PTR_W'(tx_wr + 1'b1) != tx_rd) begin
            tx_ring[tx_wr] = op.tx_data;
            tx_wr          = tx_wr + 1'b1;
            r.tx_accepted  = 1'b1;
          end
          run_port_step(op, r);
        end
        FUNC_RD: begin
          if (rx_wr != rx_rd) begin
            r.read_data  = rx_ring[rx_rd];
            r.read_valid = 1'b1;
            rx_rd        = rx_rd + 1'b1;
          end
        end
        FUNC_EV: begin
          run_port_step(op, r);
        end
        default: begin
        end
      endcase
      r.rx_count = 8'(PTR_W'(rx_wr - rx_rd));
      due_results.push_back(r);
    endfunction

    function void compare_field(string field, logic [7:0] want, logic [7:0] got);
      if (got !== want) begin
        $display("%0t ns: mismatch in %s: expected %0h, actual %0h", $time, field, want, got);
        errors++;
      end
    endfunction

    function void check_result(result_word_t got);
      result_word_t want;
      if (due_results.size() == 0) begin
        $display("%0t ns: unexpected result: expected none, actual %h", $time, got);
        errors++;
        return;
      end
      want = due_results.pop_front();
      compare_field("read_data", want.read_data, got.read_data);
      compare_field("read_valid", 8'(want.read_valid), 8'(got.read_valid));
      compare_field("rx_count", want.rx_count, got.rx_count);
      compare_field("tx_accepted", 8'(want.tx_accepted), 8'(got.tx_accepted));
      compare_field("send_valid", 8'(want.send_valid), 8'(got.send_valid));
      compare_field("send_data", want.send_data, got.send_data);
      compare_field("rx_dropped", 8'(want.rx_dropped), 8'(got.rx_dropped));
      compare_field("pad", 8'(want.pad), 8'(got.pad));
    endfunction
  endclass

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [23:0] in_tdata   = '0;
  logic [1:0]  in_tuser   = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;

  int idle_pct   = 0;
  int stall_pct  = 0;
  int hold_left  = 0;
  int cycle_count = 0;

  ps2_ring_scoreboard sb = new();

  ps2_port_rx_tx_ring_buffers_core #(
    .RING_DEPTH(RING_DEPTH)
  ) DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      sb.check_result(out_tdata);
    end
    if (rst_n && in_tvalid && in_tready) begin
      sb.note_op(in_tuser, in_tdata);
    end
  end

  // hold off for a counted stretch, else stall at random
  initial begin
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  task automatic push_op(input logic [1:0] func, input logic [7:0] tx, input logic recv,
                         input logic [7:0] pdata, input logic cts);
    op_word_t op;
    op = '0;
    op.tx_data   = tx;
    op.port_recv = recv;
    op.port_data = pdata;
    op.port_cts  = cts;
    @(negedge clk);
    while ($urandom_range(99) < idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= op;
    in_tuser  <= func;
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic push_random(input int n);
    int         rd_pct;
    int         wr_pct;
    int         recv_pct;
    int         cts_pct;
    int         pick;
    logic [1:0] func;
    for (int i = 0; i < n; i++) begin
      if (i % 50 == 0) begin
        case ($urandom_range(2))
          0: begin
            rd_pct = 10; wr_pct = 40; recv_pct = 85; cts_pct = 15;
          end
          1: begin
            rd_pct = 35; wr_pct = 30; recv_pct = 50; cts_pct = 50;
          end
          default: begin
            rd_pct = 55; wr_pct = 15; recv_pct = 15; cts_pct = 85;
          end
        endcase
      end
      pick = $urandom_range(99);
      if (pick < rd_pct) func = FUNC_RD;
      else if (pick < rd_pct + wr_pct) func = FUNC_WR;
      else if (pick < 95) func = FUNC_EV;
      else func = FUNC_NOP;
      push_op(func, 8'($urandom_range(255)), $urandom_range(99) < recv_pct,
              8'($urandom_range(255)), $urandom_range(99) < cts_pct);
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    push_op(FUNC_RD, 8'hff, 1'b1, 8'hff, 1'b1);
    push_op(FUNC_NOP, 8'hff, 1'b1, 8'hff, 1'b1);
    push_op(FUNC_EV, 8'h00, 1'b0, 8'h00, 1'b1);
    // fill both rings to full, then overflow each
    for (int i = 0; i < 16; i++) begin
      push_op(FUNC_WR, 8'(i * 17), 1'b1, 8'(255 - i * 17), 1'b0);
    end
    push_op(FUNC_EV, 8'h00, 1'b1, 8'h5a, 1'b1);
    push_op(FUNC_WR, 8'hff, 1'b0, 8'h00, 1'b1);
    push_op(FUNC_RD, 8'h00, 1'b0, 8'h00, 1'b0);
    push_op(FUNC_RD, 8'hff, 1'b1, 8'hff, 1'b1);

    // pause the sender until every result is back
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);

    hold_left = 120;
    push_random(40);

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin
          idle_pct = 0;  stall_pct = 0;
        end
        1: begin
          idle_pct = 83; stall_pct = 0;
        end
        2: begin
          idle_pct = 0;  stall_pct = 83;
        end
        default: begin
          idle_pct = 34; stall_pct = 34;
        end
      endcase
      push_random(470);
    end

    @(negedge clk);
    in_tvalid <= 1'b0;
    stall_pct = 0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (sb.errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
